[hw/rtl/aspd_pkg.sv]
// Shared types and constants for the alert stage pattern driver.
package aspd_pkg;

  typedef enum logic [2:0] {
    STAGE_NORMAL   = 3'd0,
    STAGE_DROWSY   = 3'd1,
    STAGE_FATIGUE  = 3'd2,
    STAGE_CRITICAL = 3'd3,
    STAGE_STANDBY  = 3'd4
  } stage_t;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_BYTE = 1'b1
  } func_t;

  // Command characters.
  localparam logic [7:0] CMD_STAGE0  = 8'h30;
  localparam logic [7:0] CMD_STAGE1  = 8'h31;
  localparam logic [7:0] CMD_STAGE2  = 8'h32;
  localparam logic [7:0] CMD_STAGE3  = 8'h33;
  localparam logic [7:0] CMD_STBY_LC = 8'h78;
  localparam logic [7:0] CMD_STBY_UC = 8'h58;

  // Counter limits.
  localparam logic [9:0]  TIS_MAX       = 10'd1023;
  localparam logic [10:0] LONG_LAST     = 11'd1999;
  localparam logic [9:0]  SHORT_LAST    = 10'd599;

  // Drowsy pattern thresholds on the in-stage timer.
  localparam logic [9:0]  DROWSY_BUZZ   = 10'd200;
  localparam logic [9:0]  DROWSY_VIB    = 10'd600;

  // Fatigue pattern thresholds on the long phase.
  localparam logic [10:0] FAT_BLINK_A   = 11'd500;
  localparam logic [10:0] FAT_BLINK_B   = 11'd1000;
  localparam logic [10:0] FAT_BLINK_C   = 11'd1500;
  localparam logic [10:0] FAT_BEEP1_END = 11'd120;
  localparam logic [10:0] FAT_BEEP2_BEG = 11'd240;
  localparam logic [10:0] FAT_BEEP2_END = 11'd360;
  localparam logic [10:0] FAT_VIB_END   = 11'd400;

  // Critical pattern thresholds on the short phase.
  localparam logic [9:0]  CRIT_BLINK_A  = 10'd150;
  localparam logic [9:0]  CRIT_BLINK_B  = 10'd300;
  localparam logic [9:0]  CRIT_BLINK_C  = 10'd450;
  localparam logic [9:0]  CRIT_BUZZ_END = 10'd300;

  typedef struct packed {
    logic red;
    logic amber;
    logic green;
    logic buzzer;
    logic vibration;
  } drive_t;

endpackage

[hw/rtl/alert_stage_pattern_driver_core.sv]
// Top level of the alert stage pattern driver: state update and result register.
//
//  Channel  Direction  Ports                               Meaning
//  in_      input      in_valid/in_ready, in_func,         millisecond tick or command byte
//                      in_rx_byte
//  out_     output     out_valid/out_ready, out_red_on,    drive levels and stage after
//                      out_amber_on, out_green_on,         each input transaction
//                      out_buzzer_on, out_vibration_on,
//                      out_alert_stage
//
// Each input transaction updates the state in the cycle it is accepted and its
// result appears in the output register on the next cycle; one transaction can
// be taken every cycle while the output register is not held full by a stall.
// The single output register sets the rate: a new transaction is taken whenever
// that register is empty or is being emptied in the same cycle.
// A stalled output holds its result and blocks input only while it is full.
// Synchronous active-low reset returns to the normal stage with the timer and
// both phases at zero, and empties the output register.
module alert_stage_pattern_driver_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_red_on,
  output logic       out_amber_on,
  output logic       out_green_on,
  output logic       out_buzzer_on,
  output logic       out_vibration_on,
  output logic [2:0] out_alert_stage
);

  aspd_pkg::stage_t stage_r, stage_nxt;
  logic [9:0]       tis_r, tis_nxt;
  logic [10:0]      phase_long_r, phase_long_nxt;
  logic [9:0]       phase_short_r, phase_short_nxt;

  logic             out_valid_r, out_valid_nxt;
  aspd_pkg::drive_t drive_r;
  aspd_pkg::stage_t out_stage_r;
  aspd_pkg::drive_t drive_nxt;
  logic             in_fire;

  // Input is taken whenever the result register is free or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Next state for the accepted transaction.
  always_comb begin
    stage_nxt       = stage_r;
    tis_nxt         = tis_r;
    phase_long_nxt  = phase_long_r;
    phase_short_nxt = phase_short_r;
    if (aspd_pkg::func_t'(in_func) == aspd_pkg::FUNC_TICK) begin
      if (tis_r != aspd_pkg::TIS_MAX) begin
        tis_nxt = tis_r + 10'd1;
      end
      // The phases wrap at their modulus; a value already past it also wraps.
      phase_long_nxt  = (phase_long_r >= aspd_pkg::LONG_LAST) ? '0 : phase_long_r + 11'd1;
      phase_short_nxt = (phase_short_r >= aspd_pkg::SHORT_LAST) ? '0 : phase_short_r + 10'd1;
    end else begin
      case (in_rx_byte) inside
        aspd_pkg::CMD_STAGE0, aspd_pkg::CMD_STAGE1,
        aspd_pkg::CMD_STAGE2, aspd_pkg::CMD_STAGE3: begin
          // Only a real change of stage restarts the in-stage timer.
          if (aspd_pkg::stage_t'({1'b0, in_rx_byte[1:0]}) != stage_r) begin
            stage_nxt = aspd_pkg::stage_t'({1'b0, in_rx_byte[1:0]});
            tis_nxt   = '0;
          end
        end
        aspd_pkg::CMD_STBY_LC, aspd_pkg::CMD_STBY_UC: begin
          // Standby always clears the timer, even when repeated.
          stage_nxt = aspd_pkg::STAGE_STANDBY;
          tis_nxt   = '0;
        end
        default: begin
          // Unknown characters are ignored.
        end
      endcase
    end
  end

  // The pattern is worked out from the updated state, as the result shows it.
  aspd_pattern u_pattern (
    .stage         (stage_nxt),
    .time_in_stage (tis_nxt),
    .phase_long    (phase_long_nxt),
    .phase_short   (phase_short_nxt),
    .drive         (drive_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r       <= aspd_pkg::STAGE_NORMAL;
      tis_r         <= '0;
      phase_long_r  <= '0;
      phase_short_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        stage_r       <= stage_nxt;
        tis_r         <= tis_nxt;
        phase_long_r  <= phase_long_nxt;
        phase_short_r <= phase_short_nxt;
      end
    end
  end

  // Result payload register; it needs no reset as out_valid qualifies it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      drive_r     <= drive_nxt;
      out_stage_r <= stage_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red_on       = drive_r.red;
  assign out_amber_on     = drive_r.amber;
  assign out_green_on     = drive_r.green;
  assign out_buzzer_on    = drive_r.buzzer;
  assign out_vibration_on = drive_r.vibration;
  assign out_alert_stage  = out_stage_r;

  // Standby results are fully dark.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stage_r == aspd_pkg::STAGE_STANDBY) |-> (drive_r == '0))
    else $error("standby result with a drive level set");

  // Green is lit only in the normal stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && drive_r.green) |-> (out_stage_r == aspd_pkg::STAGE_NORMAL))
    else $error("green lamp outside the normal stage");

  // Both phases stay below their modulus.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_long_r <= aspd_pkg::LONG_LAST) && (phase_short_r <= aspd_pkg::SHORT_LAST))
    else $error("phase counter beyond its modulus");

  // A command byte never moves the phases.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && aspd_pkg::func_t'(in_func) == aspd_pkg::FUNC_BYTE) |=>
      ($stable(phase_long_r) && $stable(phase_short_r)))
    else $error("phase moved on a command byte");

  // The stage only changes when a transaction is accepted.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(stage_r))
    else $error("stage changed without an input transaction");

endmodule

[hw/rtl/aspd_pattern.sv]
// Output pattern decoder: maps stage, in-stage timer and phases to drive levels.
module aspd_pattern (
  input  aspd_pkg::stage_t stage,
  input  logic [9:0]       time_in_stage,
  input  logic [10:0]      phase_long,
  input  logic [9:0]       phase_short,
  output aspd_pkg::drive_t drive
);

  always_comb begin
    drive = '0;
    unique case (stage)
      aspd_pkg::STAGE_NORMAL: begin
        drive.green = 1'b1;
      end
      aspd_pkg::STAGE_DROWSY: begin
        drive.amber     = 1'b1;
        drive.buzzer    = (time_in_stage < aspd_pkg::DROWSY_BUZZ);
        drive.vibration = (time_in_stage < aspd_pkg::DROWSY_VIB);
      end
      aspd_pkg::STAGE_FATIGUE: begin
        // Odd half-second slots of the two-second phase.
        drive.amber = ((phase_long >= aspd_pkg::FAT_BLINK_A) &&
                       (phase_long <  aspd_pkg::FAT_BLINK_B)) ||
                      (phase_long >= aspd_pkg::FAT_BLINK_C);
        drive.buzzer = (phase_long < aspd_pkg::FAT_BEEP1_END) ||
                       ((phase_long >= aspd_pkg::FAT_BEEP2_BEG) &&
                        (phase_long <  aspd_pkg::FAT_BEEP2_END));
        drive.vibration = (phase_long < aspd_pkg::FAT_VIB_END);
      end
      aspd_pkg::STAGE_CRITICAL: begin
        drive.red = ((phase_short >= aspd_pkg::CRIT_BLINK_A) &&
                     (phase_short <  aspd_pkg::CRIT_BLINK_B)) ||
                    (phase_short >= aspd_pkg::CRIT_BLINK_C);
        drive.buzzer    = (phase_short < aspd_pkg::CRIT_BUZZ_END);
        drive.vibration = 1'b1;
      end
      default: begin
        drive = '0;
      end
    endcase
  end

endmodule

[sim/aspd_result_checker.sv]
// Scoreboard for the alert stage pattern driver: predicts each result and checks it.
module aspd_result_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_red_on,
  input  logic       out_amber_on,
  input  logic       out_green_on,
  input  logic       out_buzzer_on,
  input  logic       out_vibration_on,
  input  logic [2:0] out_alert_stage,
  output int         mismatches,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [9:0]  MS_CEILING  = 10'd1023;
  localparam logic [10:0] LONG_TOP    = 11'd1999;
  localparam logic [9:0]  SHORT_TOP   = 10'd599;

  typedef struct packed {
    aspd_pkg::drive_t drive;
    logic [2:0]       stage;
  } indication_t;

  aspd_pkg::stage_t stage_now;
  logic [9:0]       ms_in_stage;
  logic [10:0]      long_phase;
  logic [9:0]       short_phase;
  indication_t      expected_levels[$];
  indication_t      want;
  indication_t      got;

  // Lamp, buzzer and vibration levels for a given stage and timer state.
  function automatic indication_t pattern_levels(input aspd_pkg::stage_t st,
                                                 input logic [9:0] ms,
                                                 input logic [10:0] lp, input logic [9:0] sp);
    indication_t ind;
    ind.drive = '0;
    ind.stage = st;
    case (st)
      aspd_pkg::STAGE_NORMAL: begin
        ind.drive.green = 1'b1;
      end
      aspd_pkg::STAGE_DROWSY: begin
        ind.drive.amber     = 1'b1;
        ind.drive.buzzer    = (ms < 10'd200);
        ind.drive.vibration = (ms < 10'd600);
      end
      aspd_pkg::STAGE_FATIGUE: begin
        ind.drive.amber     = ((lp / 11'd500) % 2) == 1;
        ind.drive.buzzer    = (lp < 11'd120) || (lp >= 11'd240 && lp < 11'd360);
        ind.drive.vibration = (lp < 11'd400);
      end
      aspd_pkg::STAGE_CRITICAL: begin
        ind.drive.red       = ((sp / 10'd150) % 2) == 1;
        ind.drive.buzzer    = (sp < 10'd300);
        ind.drive.vibration = 1'b1;
      end
      default: ;
    endcase
    return ind;
  endfunction

  task automatic advance_state(input logic f, input logic [7:0] b);
    if (f == aspd_pkg::FUNC_TICK) begin
      if (ms_in_stage != MS_CEILING) ms_in_stage = ms_in_stage + 10'd1;
      long_phase  = (long_phase == LONG_TOP) ? '0 : long_phase + 11'd1;
      short_phase = (short_phase == SHORT_TOP) ? '0 : short_phase + 10'd1;
    end else begin
      case (b)
        aspd_pkg::CMD_STAGE0, aspd_pkg::CMD_STAGE1,
        aspd_pkg::CMD_STAGE2, aspd_pkg::CMD_STAGE3: begin
          // Re-selecting the current stage leaves the timer running.
          if (aspd_pkg::stage_t'(b[2:0]) != stage_now) begin
            stage_now   = aspd_pkg::stage_t'(b[2:0]);
            ms_in_stage = '0;
          end
        end
        aspd_pkg::CMD_STBY_LC, aspd_pkg::CMD_STBY_UC: begin
          stage_now   = aspd_pkg::STAGE_STANDBY;
          ms_in_stage = '0;
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stage_now   = aspd_pkg::STAGE_NORMAL;
      ms_in_stage = '0;
      long_phase  = '0;
      short_phase = '0;
      expected_levels.delete();
      outstanding <= 0;
    end else begin
      // Retire the oldest result before queueing the new one: as the result is
      // registered, a result never belongs to the transaction taken at the
      // same edge.
      if (out_valid && out_ready) begin
        got.drive = {out_red_on, out_amber_on, out_green_on, out_buzzer_on, out_vibration_on};
        got.stage = out_alert_stage;
        if (expected_levels.size() == 0) begin
          $display("%0t: result expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = expected_levels.pop_front();
          check_field("red_on",       int'(want.drive.red),       int'(got.drive.red));
          check_field("amber_on",     int'(want.drive.amber),     int'(got.drive.amber));
          check_field("green_on",     int'(want.drive.green),     int'(got.drive.green));
          check_field("buzzer_on",    int'(want.drive.buzzer),    int'(got.drive.buzzer));
          check_field("vibration_on", int'(want.drive.vibration), int'(got.drive.vibration));
          check_field("alert_stage",  int'(want.stage),           int'(got.stage));
        end
      end
      if (in_valid && in_ready) begin
        advance_state(in_func, in_rx_byte);
        expected_levels.push_back(pattern_levels(stage_now, ms_in_stage, long_phase,
                                                 short_phase));
      end
      outstanding <= expected_levels.size();
    end
  end

endmodule

[sim/tb_alert_stage_pattern_driver_core.sv]
// Top of the alert stage pattern driver testbench: clock, reset, stimulus and verdict.
module tb_alert_stage_pattern_driver_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Random transactions to send after the directed part. Occasional long runs
  // of ticks carry the drowsy timer past the end of its vibration window.
  localparam int RANDOM_ITEMS = 928;
  // Cycles without any transaction on either channel before the run is abandoned.
  localparam int STALL_LIMIT  = 2000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_func;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_red_on;
  logic       out_amber_on;
  logic       out_green_on;
  logic       out_buzzer_on;
  logic       out_vibration_on;
  logic [2:0] out_alert_stage;

  int   mismatches;
  int   outstanding;
  int   sent_items;
  int   idle_cycles;
  // When set, neither side inserts gaps, so back-to-back transactions occur.
  logic calm;

  alert_stage_pattern_driver_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red_on       (out_red_on),
    .out_amber_on     (out_amber_on),
    .out_green_on     (out_green_on),
    .out_buzzer_on    (out_buzzer_on),
    .out_vibration_on (out_vibration_on),
    .out_alert_stage  (out_alert_stage)
  );

  // The checker watches both channels, predicts every result and counts
  // mismatches; this module only produces stimulus and reports the verdict.
  aspd_result_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red_on       (out_red_on),
    .out_amber_on     (out_amber_on),
    .out_green_on     (out_green_on),
    .out_buzzer_on    (out_buzzer_on),
    .out_vibration_on (out_vibration_on),
    .out_alert_stage  (out_alert_stage),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length for either side: mostly none or short, occasionally long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Offers one transaction and holds it until it is taken. Valid is lowered
  // only when a gap follows, so a back-to-back transaction keeps it high.
  task automatic send_item(input aspd_pkg::func_t f, input logic [7:0] b);
    int gap;
    in_valid   <= 1'b1;
    in_func    <= f;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: the sink accepts for a while, then stalls for a random time.
  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat (calm ? 1 : $urandom_range(1, 8)) @(posedge clk);
      stall = calm ? 0 : idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Watchdog: a correct block never goes this long without a transaction
  // on one channel or the other.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] head;
    int         pick;
    int         run;
    logic       long_run;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_func     <= aspd_pkg::FUNC_TICK;
    in_rx_byte  <= 8'h00;
    calm        = 1'b0;
    sent_items  = 0;
    idle_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every stage, repeated selections, both standby letters,
    // ignored bytes at the extremes of the byte range, and ticks that carry
    // a stage digit which must not be acted upon.
    send_item(aspd_pkg::FUNC_TICK, 8'h00);
    send_item(aspd_pkg::FUNC_BYTE, aspd_pkg::CMD_STAGE0);   // already normal, nothing changes
    send_item(aspd_pkg::FUNC_BYTE, aspd_pkg::CMD_STAGE1);
    send_item(aspd_pkg::FUNC_TICK, 8'h00);
    send_item(aspd_pkg::FUNC_BYTE, aspd_pkg::CMD_STAGE1);   // same stage, timer keeps running
    send_item(aspd_pkg::FUNC_TICK, 8'hFF);
    send_item(aspd_pkg::FUNC_BYTE, aspd_pkg::CMD_STAGE2);
    send_item(aspd_pkg::FUNC_TICK, 8'h00);
    send_item(aspd_pkg::FUNC_BYTE, aspd_pkg::CMD_STAGE3);
    send_item(aspd_pkg::FUNC_TICK, 8'h00);
    send_item(aspd_pkg::FUNC_BYTE, aspd_pkg::CMD_STBY_LC);
    send_item(aspd_pkg::FUNC_TICK, 8'h00);
    send_item(aspd_pkg::FUNC_BYTE, aspd_pkg::CMD_STBY_LC);  // standby again clears the timer
    send_item(aspd_pkg::FUNC_BYTE, aspd_pkg::CMD_STBY_UC);
    send_item(aspd_pkg::FUNC_BYTE, 8'h00);        // unknown bytes are ignored
    send_item(aspd_pkg::FUNC_BYTE, 8'hFF);
    send_item(aspd_pkg::FUNC_BYTE, 8'h34);
    send_item(aspd_pkg::FUNC_BYTE, 8'h2F);
    send_item(aspd_pkg::FUNC_TICK, aspd_pkg::CMD_STAGE3);   // a tick ignores its byte
    send_item(aspd_pkg::FUNC_BYTE, 8'h79);
    send_item(aspd_pkg::FUNC_BYTE, aspd_pkg::CMD_STAGE0);
    send_item(aspd_pkg::FUNC_TICK, 8'hFF);

    // Random part: each burst opens with a command, mostly a well-formed
    // stage selection, then a run of ticks. Occasional long runs carry the
    // drowsy timer past its vibration window; a run that would overshoot is cut
    // short so the total stays at the intended number of transactions.
    while (sent_items < 22 + RANDOM_ITEMS) begin
      calm     = ($urandom_range(0, 4) == 0);
      long_run = ($urandom_range(0, 99) < 6);
      pick     = $urandom_range(0, 99);
      if (long_run)
        head = $urandom_range(0, 1) ? aspd_pkg::CMD_STAGE1
                                    : aspd_pkg::CMD_STAGE0 + 8'($urandom_range(0, 3));
      else if (pick < 70)
        head = aspd_pkg::CMD_STAGE0 + 8'($urandom_range(0, 3));
      else if (pick < 80)
        head = $urandom_range(0, 1) ? aspd_pkg::CMD_STBY_LC : aspd_pkg::CMD_STBY_UC;
      else
        head = 8'($urandom_range(0, 255));
      send_item(aspd_pkg::FUNC_BYTE, head);

      if (long_run)
        run = $urandom_range(400, 700);
      else if ($urandom_range(0, 99) < 75)
        run = $urandom_range(1, 40);
      else
        run = $urandom_range(41, 300);
      if (run > 22 + RANDOM_ITEMS - sent_items)
        run = 22 + RANDOM_ITEMS - sent_items;
      repeat (run) begin
        if (!long_run && $urandom_range(0, 99) < 4)
          send_item(aspd_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)));
        else
          send_item(aspd_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    // The watchdog bounds this wait should a result never arrive.
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/aspd_pkg.sv
hw/rtl/aspd_pattern.sv
hw/rtl/alert_stage_pattern_driver_core.sv
sim/aspd_result_checker.sv
sim/tb_alert_stage_pattern_driver_core.sv
